/* rtl/core/jwat_pkg.sv */
// Package for the journal write absorb table: payload types, status codes and constants.
`default_nettype none

package jwat_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_BLOCK_BYTES = 512;

  localparam int BLK_W   = 24;
  localparam int OFF_W   = 9;
  localparam int LEN_W   = 10;
  // Stored range length keeps one more bit than the port field.
  // The bounding range can never end past 1534, so this is exact.
  localparam int SLEN_W  = 11;
  localparam int END_W   = 12;
  localparam int IDX_W   = 4;
  localparam int USED_W  = 5;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int LOG_W   = 11;
  localparam logic [LOG_W-1:0] LOG_AREA_RESET = 11'd64;

  typedef enum logic [2:0] {
    ST_ABSORBED  = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_TXN    = 3'd3,
    ST_BAD_RANGE = 3'd4,
    ST_DRAINED   = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_DRAIN  = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [BLK_W-1:0]  block_number;
    logic [OFF_W-1:0]  start_offset;
    logic [LEN_W-1:0]  slice_length;
    logic              in_transaction;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [BLK_W-1:0]  entry_block;
    logic [OFF_W-1:0]  entry_offset;
    logic [LEN_W-1:0]  entry_length;
    logic [IDX_W-1:0]  entry_index;
    logic [USED_W-1:0] entries_used;
    logic              last;
  } out_t;

  // One table slot as it sits in the slot memory.
  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
    logic [SLEN_W-1:0] len;
  } slot_t;

  // What the compare and merge unit reports for one visited slot.
  typedef struct packed {
    logic              hit;
    logic [OFF_W-1:0]  lo;
    logic [SLEN_W-1:0] len;
  } merge_t;

endpackage

`default_nettype wire

/* rtl/core/jwat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module jwat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/jwat_merge.sv */
// Shared compare and merge unit: matches one slot against the request and forms the bounding range.
`default_nettype none

module jwat_merge (
  input  wire jwat_pkg::slot_t               entry,
  input  wire logic [jwat_pkg::BLK_W-1:0]    req_blk,
  input  wire logic [jwat_pkg::OFF_W-1:0]    req_off,
  input  wire logic [jwat_pkg::LEN_W-1:0]    req_len,
  output jwat_pkg::merge_t                   res
);
  import jwat_pkg::*;

  logic [END_W-1:0] old_end;
  logic [END_W-1:0] new_end;
  logic [END_W-1:0] hi;
  logic [OFF_W-1:0] lo;
  logic [END_W-1:0] span;

  always_comb begin
    old_end = END_W'(entry.off) + END_W'(entry.len);
    new_end = END_W'(req_off) + END_W'(req_len);
    lo      = (entry.off < req_off) ? entry.off : req_off;
    hi      = (old_end > new_end) ? old_end : new_end;
    span    = hi - END_W'(lo);
    res.hit = (entry.blk == req_blk);
    res.lo  = lo;
    res.len = span[SLEN_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/core/journal_write_absorb_table.sv */
// Top level of the journal write absorb table: sequencer, slot memory and register port.
`default_nettype none

// The block keeps a table of logged disk writes, one slot per home block with
// the byte range modified in it. A record request is checked first (table
// full, no open transaction, range past the end of the block); a refused
// request gives one result with its status and leaves the table alone. An
// accepted record request is then compared against the stored slots one slot
// per cycle through a single compare and merge unit fed by the slot memory's
// one read port. On a match the stored range widens to cover both ranges; if
// no slot matches, the block is appended. A drain request reads the slots out
// in order, one result transfer per cycle while the output is not stalled,
// marks the final one with last and empties the table; an empty table gives a
// single drain empty result. The block takes no new input while one request
// is in work, but it does take the next input while the final result still
// waits in the output register. The register log_area_blocks sits at byte
// address 0 of the APB-style port and resets to 64; it should be written only
// while the block is idle.
module journal_write_absorb_table #(
  parameter int MAX_ENTRIES = jwat_pkg::DEF_MAX_ENTRIES,
  parameter int BLOCK_BYTES = jwat_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire jwat_pkg::in_t                in_data,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output jwat_pkg::out_t                    out_data,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jwat_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [jwat_pkg::CFG_DW-1:0]  pwdata,
  output logic      [jwat_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);
  import jwat_pkg::*;

  // Slot index width and count width follow the table depth.
  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  // Width wide enough for offset plus length and for the block size.
  localparam int CMPW = ($clog2(BLOCK_BYTES + 1) > 11) ? $clog2(BLOCK_BYTES + 1) : 11;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t            state_r,     state_nxt;
  in_t               req_r,       req_nxt;
  logic [IW-1:0]     idx_r,       idx_nxt;
  logic [CW-1:0]     used_r,      used_nxt;
  logic [CW-1:0]     cnt_r,       cnt_nxt;
  out_t              pend_r,      pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r,  out_data_nxt;
  logic [LOG_W-1:0]  log_area_r;

  logic              out_free;
  logic              cfg_wr;
  logic              is_full;
  logic              bad_range;
  logic              last_drain;
  logic              last_slot;

  logic              ram_wr_en;
  logic [IW-1:0]     ram_wr_addr;
  slot_t             ram_wr_data;
  logic [$bits(slot_t)-1:0] ram_rd_raw;
  slot_t             slot_rd;
  merge_t            mrg;

  // Slot memory: one write and one registered read per cycle.
  jwat_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (idx_nxt),
    .rd_data (ram_rd_raw)
  );

  assign slot_rd = slot_t'(ram_rd_raw);

  // The one compare and merge unit, reused for every slot that is visited.
  jwat_merge u_merge (
    .entry   (slot_rd),
    .req_blk (req_r.block_number),
    .req_off (req_r.start_offset),
    .req_len (req_r.slice_length),
    .res     (mrg)
  );

  // Register port. Address bits below the word are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1:2] == '0);
  assign prdata = (paddr[CFG_AW-1:2] == '0) ? CFG_DW'(log_area_r) : '0;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register may be loaded when it is empty or is being taken now.
  assign out_free = !out_valid_r || !out_stall;

  // Admission checks on the incoming record request, made before any search.
  assign is_full   = (used_r >= CW'(MAX_ENTRIES)) ||
                     ((LOG_W'(used_r) + LOG_W'(1)) >= log_area_r);
  assign bad_range = (CMPW'(in_data.start_offset) + CMPW'(in_data.slice_length)) >
                     CMPW'(BLOCK_BYTES);

  assign last_slot  = ((CW'(idx_r) + CW'(1)) == used_r);
  assign last_drain = ((CW'(idx_r) + CW'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = '{blk: req_r.block_number, off: req_r.start_offset,
                      len: SLEN_W'(req_r.slice_length)};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          req_nxt  = in_data;
          pend_nxt = '{status: ST_FULL, entry_block: '0, entry_offset: '0,
                       entry_length: '0, entry_index: '0,
                       entries_used: USED_W'(used_r), last: 1'b1};
          state_nxt = S_EMIT;
          if (in_data.req_type == REQ_DRAIN) begin
            cnt_nxt  = used_r;
            used_nxt = '0;
            pend_nxt.entries_used = '0;
            if (used_r == '0) begin
              pend_nxt.status = ST_EMPTY;
            end else begin
              state_nxt = S_DRAIN;
            end
          end else if (is_full) begin
            pend_nxt.status = ST_FULL;
          end else if (!in_data.in_transaction) begin
            pend_nxt.status = ST_NO_TXN;
          end else if (bad_range) begin
            pend_nxt.status = ST_BAD_RANGE;
          end else if (used_r == '0) begin
            // Nothing to search: append straight into slot zero.
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = '{blk: in_data.block_number, off: in_data.start_offset,
                            len: SLEN_W'(in_data.slice_length)};
            used_nxt    = CW'(1);
            pend_nxt    = '{status: ST_APPENDED, entry_block: in_data.block_number,
                            entry_offset: in_data.start_offset,
                            entry_length: in_data.slice_length, entry_index: '0,
                            entries_used: USED_W'(1), last: 1'b1};
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // The read data holds slot idx_r in this cycle.
        if (mrg.hit) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r;
          ram_wr_data = '{blk: req_r.block_number, off: mrg.lo, len: mrg.len};
          pend_nxt    = '{status: ST_ABSORBED, entry_block: req_r.block_number,
                          entry_offset: mrg.lo, entry_length: mrg.len[LEN_W-1:0],
                          entry_index: IDX_W'(idx_r),
                          entries_used: USED_W'(used_r), last: 1'b1};
          state_nxt   = S_EMIT;
        end else if (last_slot) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = used_r[IW-1:0];
          used_nxt    = used_r + CW'(1);
          pend_nxt    = '{status: ST_APPENDED, entry_block: req_r.block_number,
                          entry_offset: req_r.start_offset,
                          entry_length: req_r.slice_length,
                          entry_index: IDX_W'(used_r),
                          entries_used: USED_W'(used_r + CW'(1)), last: 1'b1};
          state_nxt   = S_EMIT;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_DRAIN: begin
        // Hold the slot index while the output is blocked, so the read repeats.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_DRAINED, entry_block: slot_rd.blk,
                            entry_offset: slot_rd.off,
                            entry_length: slot_rd.len[LEN_W-1:0],
                            entry_index: IDX_W'(idx_r), entries_used: '0,
                            last: last_drain};
          if (last_drain) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      log_area_r  <= LOG_AREA_RESET;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        log_area_r <= pwdata[LOG_W-1:0];
      end
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/jwat_checker.sv */
// Port-level checker for the journal write absorb table, bound to the top level.
`default_nettype none

module jwat_checker #(
  parameter int MAX_ENTRIES = 16
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire jwat_pkg::out_t out_data
);
  import jwat_pkg::*;

  // An accepted request keeps the input side closed in the cycle after the transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted in the cycle after a transfer");

  // A blocked result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Drain results always report an emptied table.
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_DRAINED || out_data.status == ST_EMPTY))
    |-> (out_data.entries_used == '0))
    else $error("drain result with nonzero entry count");

  // Refusals are single results with zeroed entry block and index and an in-range count.
  a_refusal_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL || out_data.status == ST_NO_TXN ||
                   out_data.status == ST_BAD_RANGE))
    |-> (out_data.last && out_data.entry_block == '0 && out_data.entry_index == '0 &&
         out_data.entries_used <= USED_W'(MAX_ENTRIES)))
    else $error("malformed refusal result");

endmodule

bind journal_write_absorb_table jwat_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_jwat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
